>>> design/srwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwt_pkg
// Types and constants shared by the slab random-walk transport step block.
// ----------------------------------------------------------------------------
package srwt_pkg;

    localparam int LOG_FRAC = 28;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    localparam logic [30:0] MFP_RESET   = 31'd1677722;
    localparam logic [30:0] THICK_RESET = 31'd16777216;
    localparam logic [31:0] CAPT_RESET  = 32'd214748365;
    localparam logic [19:0] STEPS_RESET = 20'd1000000;

    typedef enum logic [1:0] {
        REG_MEAN_FREE_PATH = 2'd0,
        REG_SLAB_THICKNESS = 2'd1,
        REG_CAPTURE_PROB   = 2'd2,
        REG_MAX_STEPS      = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        OUT_CONTINUE    = 3'd0,
        OUT_ABSORBED    = 3'd1,
        OUT_REFLECTED   = 3'd2,
        OUT_TRANSMITTED = 3'd3,
        OUT_STEP_LIMIT  = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_LOG,
        F_NAT,
        F_DIST,
        F_DISP,
        F_PUSH
    } front_state_t;

    // Displacement word passed from the front to the back.
    typedef struct packed {
        logic        capture;
        logic        neg;
        logic [31:0] dmag;
    } disp_t;

    typedef struct packed {
        outcome_t           outcome;
        logic signed [31:0] depth;
        logic [19:0]        step_number;
        logic [31:0]        absorbed_total;
        logic [31:0]        reflected_total;
        logic [31:0]        transmitted_total;
    } result_t;

endpackage

>>> design/slab_random_walk_transport_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_random_walk_transport_step
// One Monte Carlo random-walk step of a particle crossing a slab.
// ----------------------------------------------------------------------------
// Input channel: push/full carries three Q0.32 draws; a word is taken when push
// is high and full is low. Result channel: empty/pop; the oldest result sits on
// the result ports while empty is low and leaves when pop is high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and a write takes effect at the next edge.
// A step passes through the front in order: the idle state takes it, the
// normalising shift runs until the leading one is seen, 28 squarings of the log
// unit follow, then three scaling multiplies and the queue push; a draw of zero
// skips the normalise, the log and the first two multiplies. full stays high
// while the front works on a step, so the front takes a new step only after it
// has pushed the last one. The back adds one result per cycle while the inner
// queue holds a displacement and the output queue has room.
// Reset clears the walk depth, step count, tallies and both queues, and loads
// the default configuration. When the receiver stalls, two results wait in the
// output queue, two displacements in the inner queue and one more step in the
// front before full holds off further steps.
// ----------------------------------------------------------------------------
module slab_random_walk_transport_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] uniform_distance,
    input  logic [31:0] uniform_direction,
    input  logic [31:0] uniform_capture,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  outcome,
    output logic signed [31:0] depth,
    output logic [19:0] step_number,
    output logic [31:0] absorbed_total,
    output logic [31:0] reflected_total,
    output logic [31:0] transmitted_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import srwt_pkg::*;

    logic [30:0] mfp_reg;
    logic [30:0] thick_reg;
    logic [31:0] capt_reg;
    logic [19:0] steps_reg;

    logic    q_push, q_full, q_pop, q_empty;
    disp_t   q_wdata, q_rdata;
    logic    r_push, r_full;
    result_t r_wdata, r_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfp_reg   <= MFP_RESET;
            thick_reg <= THICK_RESET;
            capt_reg  <= CAPT_RESET;
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MEAN_FREE_PATH: mfp_reg   <= cfg_data[30:0];
                REG_SLAB_THICKNESS: thick_reg <= cfg_data[30:0];
                REG_CAPTURE_PROB:   capt_reg  <= cfg_data;
                REG_MAX_STEPS:      steps_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    srwt_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .uniform_distance    (uniform_distance),
        .uniform_direction   (uniform_direction),
        .uniform_capture     (uniform_capture),
        .mean_free_path      (mfp_reg),
        .capture_probability (capt_reg),
        .q_push              (q_push),
        .q_data              (q_wdata),
        .q_full              (q_full)
    );

    srwt_fifo #(
        .WIDTH ($bits(disp_t)),
        .DEPTH (2)
    ) u_disp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    srwt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .r_push         (r_push),
        .r_data         (r_wdata),
        .r_full         (r_full),
        .slab_thickness (thick_reg),
        .max_steps      (steps_reg)
    );

    srwt_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (r_wdata),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_rdata),
        .empty (empty)
    );

    assign outcome           = r_rdata.outcome;
    assign depth             = r_rdata.depth;
    assign step_number       = r_rdata.step_number;
    assign absorbed_total    = r_rdata.absorbed_total;
    assign reflected_total   = r_rdata.reflected_total;
    assign transmitted_total = r_rdata.transmitted_total;

endmodule

>>> design/srwt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwt_fifo
// Small synchronous queue of words with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module srwt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/srwt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwt_front
// Takes the three draws, works out the signed displacement of one step with
// separate multipliers (normalise, log by squaring, scale) and queues it.
// ----------------------------------------------------------------------------
module srwt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [31:0]          uniform_distance,
    input  logic [31:0]          uniform_direction,
    input  logic [31:0]          uniform_capture,
    input  logic [30:0]          mean_free_path,
    input  logic [31:0]          capture_probability,
    output logic                 q_push,
    output srwt_pkg::disp_t      q_data,
    input  logic                 q_full
);
    import srwt_pkg::*;

    front_state_t state_reg, state_next;

    logic [31:0] m_reg;
    logic [4:0]  shift_reg;
    logic [27:0] frac_reg;
    logic [4:0]  iter_reg;
    logic [28:0] nat_reg;
    logic [30:0] dist_reg;
    logic [31:0] cmag_reg;
    logic [31:0] dmag_reg;
    logic        neg_reg;
    logic        capt_reg;

    logic        accept;
    logic [63:0] sq;
    logic [32:0] m_sq;
    logic [33:0] nlog;
    logic [63:0] nat_prod;
    logic [59:0] dist_prod;
    logic [62:0] disp_prod;
    logic        log_done;

    assign accept    = push && !full;
    assign sq        = {32'd0, m_reg} * {32'd0, m_reg};
    assign m_sq      = sq[63:31];
    // -log2 = (integer part) - fraction, integer part is one plus the shift.
    assign nlog      = {(6'(shift_reg) + 6'd1), 28'd0} - {6'd0, frac_reg};
    assign nat_prod  = {30'd0, nlog} * {34'd0, LN2_Q30};
    assign dist_prod = {29'd0, mean_free_path} * {31'd0, nat_reg};
    assign disp_prod = {32'd0, dist_reg} * {31'd0, cmag_reg};
    assign log_done  = (iter_reg == 5'(LOG_FRAC - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (uniform_distance == 32'd0) ? F_DISP : F_NORM;
                end
            end
            F_NORM: if (m_reg[31]) state_next = F_LOG;
            F_LOG:  if (log_done) state_next = F_NAT;
            F_NAT:  state_next = F_DIST;
            F_DIST: state_next = F_DISP;
            F_DISP: state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full   = 1'b1;
        q_push = 1'b0;
        case (state_reg)
            F_IDLE: full = 1'b0;
            F_PUSH: q_push = 1'b1;
            default:
            begin
                full   = 1'b1;
                q_push = 1'b0;
            end
        endcase
    end

    assign q_data = '{capture: capt_reg, neg: neg_reg, dmag: dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    m_reg     <= uniform_distance;
                    shift_reg <= '0;
                    frac_reg  <= '0;
                    iter_reg  <= '0;
                    dist_reg  <= DIST_MAX;
                    neg_reg   <= (uniform_direction > 32'h8000_0000);
                    cmag_reg  <= (uniform_direction > 32'h8000_0000)
                                 ? uniform_direction - 32'h8000_0000
                                 : 32'h8000_0000 - uniform_direction;
                    capt_reg  <= (uniform_capture < capture_probability);
                end
            end
            F_NORM:
            begin
                if (!m_reg[31])
                begin
                    m_reg     <= {m_reg[30:0], 1'b0};
                    shift_reg <= shift_reg + 5'd1;
                end
            end
            F_LOG:
            begin
                iter_reg <= iter_reg + 5'd1;
                if (m_sq[32])
                begin
                    frac_reg <= {frac_reg[26:0], 1'b1};
                    m_reg    <= m_sq[32:1];
                end
                else
                begin
                    frac_reg <= {frac_reg[26:0], 1'b0};
                    m_reg    <= m_sq[31:0];
                end
            end
            F_NAT:  nat_reg <= nat_prod[62:34];
            F_DIST:
            begin
                dist_reg <= (|dist_prod[59:55]) ? DIST_MAX : dist_prod[54:24];
            end
            F_DISP: dmag_reg <= disp_prod[62:31];
            default: ;
        endcase
    end

endmodule

>>> design/srwt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwt_back
// Applies each displacement to the walk depth, classifies the step, keeps the
// tallies and hands one result word per step to the output queue.
// ----------------------------------------------------------------------------
module srwt_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  srwt_pkg::disp_t      q_data,
    output logic                 q_pop,
    output logic                 r_push,
    output srwt_pkg::result_t    r_data,
    input  logic                 r_full,
    input  logic [30:0]          slab_thickness,
    input  logic [19:0]          max_steps
);
    import srwt_pkg::*;

    logic signed [31:0]     depth_reg, depth_next;
    logic [19:0]            steps_reg, steps_next;
    logic [COUNT_WIDTH-1:0] abs_reg, abs_next;
    logic [COUNT_WIDTH-1:0] ref_reg, ref_next;
    logic [COUNT_WIDTH-1:0] tra_reg, tra_next;

    logic        go;
    logic [33:0] nd_wide;
    logic [31:0] nd;
    logic [20:0] idx_inc;
    outcome_t    outcome;
    logic [31:0] abs_out, ref_out, tra_out;

    assign go     = !q_empty && !r_full;
    assign q_pop  = go;
    assign r_push = go;

    assign nd_wide = q_data.neg ? {{2{depth_reg[31]}}, depth_reg} - {2'b00, q_data.dmag}
                                : {{2{depth_reg[31]}}, depth_reg} + {2'b00, q_data.dmag};
    assign idx_inc = {1'b0, steps_reg} + 21'd1;

    always_comb
    begin
        if (nd_wide[33:31] == 3'b000 || nd_wide[33:31] == 3'b111)
        begin
            nd = nd_wide[31:0];
        end
        else
        begin
            nd = nd_wide[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        if (q_data.capture)
        begin
            outcome = OUT_ABSORBED;
        end
        else if (nd[31])
        begin
            outcome = OUT_REFLECTED;
        end
        else if (nd > {1'b0, slab_thickness})
        begin
            outcome = OUT_TRANSMITTED;
        end
        else if (idx_inc >= {1'b0, max_steps})
        begin
            outcome = OUT_STEP_LIMIT;
        end
        else
        begin
            outcome = OUT_CONTINUE;
        end

        abs_next   = abs_reg;
        ref_next   = ref_reg;
        tra_next   = tra_reg;
        depth_next = depth_reg;
        steps_next = steps_reg;
        if (go)
        begin
            case (outcome)
                OUT_ABSORBED:    if (abs_reg != '1) abs_next = abs_reg + 1'b1;
                OUT_REFLECTED:   if (ref_reg != '1) ref_next = ref_reg + 1'b1;
                OUT_TRANSMITTED: if (tra_reg != '1) tra_next = tra_reg + 1'b1;
                default: ;
            endcase
            if (outcome != OUT_CONTINUE)
            begin
                depth_next = '0;
                steps_next = '0;
            end
            else
            begin
                depth_next = nd;
                steps_next = idx_inc[19:0];
            end
        end
    end

    // Tallies are shown clamped to the 32-bit result fields.
    generate
        if (COUNT_WIDTH > 32)
        begin : g_wide
            assign abs_out = (|abs_next[COUNT_WIDTH-1:32]) ? '1 : abs_next[31:0];
            assign ref_out = (|ref_next[COUNT_WIDTH-1:32]) ? '1 : ref_next[31:0];
            assign tra_out = (|tra_next[COUNT_WIDTH-1:32]) ? '1 : tra_next[31:0];
        end
        else
        begin : g_narrow
            assign abs_out = 32'(abs_next);
            assign ref_out = 32'(ref_next);
            assign tra_out = 32'(tra_next);
        end
    endgenerate

    assign r_data = '{outcome: outcome, depth: nd, step_number: steps_reg,
                      absorbed_total: abs_out, reflected_total: ref_out,
                      transmitted_total: tra_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            steps_reg <= '0;
            abs_reg   <= '0;
            ref_reg   <= '0;
            tra_reg   <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            steps_reg <= steps_next;
            abs_reg   <= abs_next;
            ref_reg   <= ref_next;
            tra_reg   <= tra_next;
        end
    end

endmodule

>>> design/srwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwt_checker
// Port-level checks of the slab random-walk transport step block.
// ----------------------------------------------------------------------------
module srwt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  outcome,
    input logic [31:0] depth,
    input logic [19:0] step_number,
    input logic [31:0] absorbed_total,
    input logic [31:0] reflected_total
);
    import srwt_pkg::*;

    // A waiting word holds still until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(depth) && $stable(step_number)))
        else $error("result word changed while stalled");

    // After a walk ends, the next word shown starts a fresh walk.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && outcome != OUT_CONTINUE) |=> (empty || step_number == 20'd0))
        else $error("walk did not restart after an end");

    // A continuing step is followed by the next step of the same walk.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && outcome == OUT_CONTINUE)
        |=> (empty || step_number == $past(step_number) + 20'd1))
        else $error("step index did not advance");

    a_abs_tally: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && outcome == OUT_ABSORBED) |-> (absorbed_total != 32'd0))
        else $error("absorbed tally not bumped");

    a_ref_tally: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && outcome == OUT_REFLECTED) |-> (reflected_total != 32'd0))
        else $error("reflected tally not bumped");

endmodule

bind slab_random_walk_transport_step srwt_checker u_srwt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .outcome         (outcome),
    .depth           (depth),
    .step_number     (step_number),
    .absorbed_total  (absorbed_total),
    .reflected_total (reflected_total)
);
